// ===== src/tcsps_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsps_pkg: shared types and constants of the two-class scheduler
// Field widths, class and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tcsps_pkg;

  localparam int TAG_W  = 16;  // done_tag and request_tag port width
  localparam int ARR_W  = 32;  // arrival time width
  localparam int TIME_W = 33;  // time counter and completion_time width

  // class served last
  localparam logic [1:0] SERVED_LOW  = 2'd0;
  localparam logic [1:0] SERVED_HIGH = 2'd1;
  localparam logic [1:0] SERVED_NONE = 2'd2;

  // result status
  localparam logic STATUS_SERVED  = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // commands from the controller
  typedef struct packed {
    logic latch_item;   // capture the accepted item
    logic serve;        // pop the chosen queue, start the tag read
    logic drain;        // the serve belongs to the end-of-set drain
    logic enqueue;      // time jump, then push or drop the item
    logic load_serve;   // move the fetched tag into the output register
    logic clear_state;  // end-of-set reset of pointers, time and history
  } cmd_t;

  // status to the controller
  typedef struct packed {
    logic out_free;     // output register can take a new item this cycle
    logic can_serve;    // time below arrival and a request is queued
    logic nonempty;     // a request is queued
    logic item_last;    // current item closes the set
  } sts_t;

endpackage

// ===== src/tcsps_req_if.sv =====
// ----------------------------------------------------------------------------
// tcsps_req_if: request channel
// Valid/ready channel carrying one arrival.
// ----------------------------------------------------------------------------
interface tcsps_req_if;
  logic                       valid;
  logic                       ready;
  logic                       requester_class;
  logic [tcsps_pkg::TAG_W-1:0] request_tag;
  logic [tcsps_pkg::ARR_W-1:0] arr_time;
  logic                       last_arrival;

  modport source (
    output valid, requester_class, request_tag, arr_time, last_arrival,
    input  ready
  );
  modport sink (
    input  valid, requester_class, request_tag, arr_time, last_arrival,
    output ready
  );
endinterface

// ===== src/tcsps_res_if.sv =====
// ----------------------------------------------------------------------------
// tcsps_res_if: result channel
// Valid/ready channel carrying one completion or drop notice.
// ----------------------------------------------------------------------------
interface tcsps_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcsps_pkg::TAG_W-1:0]  done_tag;
  logic [tcsps_pkg::TIME_W-1:0] completion_time;
  logic                        result_status;
  logic                        last_result;

  modport source (
    output valid, done_tag, completion_time, result_status, last_result,
    input  ready
  );
  modport sink (
    input  valid, done_tag, completion_time, result_status, last_result,
    output ready
  );
endinterface

// ===== src/tcsps_ram.sv =====
// ----------------------------------------------------------------------------
// tcsps_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered and held.
// ----------------------------------------------------------------------------
module tcsps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/tcsps_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcsps_ctrl: scheduler sequencer
// Walks each item through serve, enqueue and the end-of-set drain.
// ----------------------------------------------------------------------------
module tcsps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  tcsps_pkg::sts_t sts_i,
  output tcsps_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;  // tag read in flight, serve phase
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DFETCH = 3'd4;  // tag read in flight, drain phase

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d          = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.out_free) begin
          if (sts_i.can_serve) begin
            cmd_o.serve = 1'b1;
            state_d     = S_FETCH;
          end else begin
            cmd_o.enqueue = 1'b1;
            state_d       = sts_i.item_last ? S_DRAIN : S_IDLE;
          end
        end
      end
      S_FETCH: begin
        if (sts_i.out_free) begin
          cmd_o.load_serve = 1'b1;
          state_d          = S_DECIDE;
        end
      end
      S_DRAIN: begin
        if (sts_i.out_free) begin
          if (sts_i.nonempty) begin
            cmd_o.serve = 1'b1;
            cmd_o.drain = 1'b1;
            state_d     = S_DFETCH;
          end else begin
            cmd_o.clear_state = 1'b1;
            state_d           = S_IDLE;
          end
        end
      end
      S_DFETCH: begin
        if (sts_i.out_free) begin
          cmd_o.load_serve = 1'b1;
          state_d          = S_DRAIN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/tcsps_dp.sv =====
// ----------------------------------------------------------------------------
// tcsps_dp: scheduler datapath
// Class queues, queue pointers, time counter, class history, output register.
// ----------------------------------------------------------------------------
module tcsps_dp #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcsps_pkg::cmd_t              cmd_i,
  output tcsps_pkg::sts_t              sts_o,
  input  logic                         requester_class_i,
  input  logic [tcsps_pkg::TAG_W-1:0]  request_tag_i,
  input  logic [tcsps_pkg::ARR_W-1:0]  arr_time_i,
  input  logic                         last_arrival_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [tcsps_pkg::TAG_W-1:0]  done_tag_o,
  output logic [tcsps_pkg::TIME_W-1:0] completion_time_o,
  output logic                         result_status_o,
  output logic                         last_result_o
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = (TAG_BITS < tcsps_pkg::TAG_W) ? TAG_BITS : tcsps_pkg::TAG_W;
  localparam logic [IW-1:0] RD_LAST = IW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   SUM_WRAP = (CW + 1)'(QUEUE_DEPTH);

  // current item
  logic                        cls_q;
  logic [SW-1:0]               tag_q;
  logic [tcsps_pkg::ARR_W-1:0] arr_q;
  logic                        last_q;

  // queue pointers, time and history
  logic [IW-1:0]                lo_rd_q, lo_rd_d, hi_rd_q, hi_rd_d;
  logic [CW-1:0]                lo_cnt_q, lo_cnt_d, hi_cnt_q, hi_cnt_d;
  logic [tcsps_pkg::TIME_W-1:0] time_q, time_d;
  logic [1:0]                   served_q, served_d;

  // serve in flight
  logic                         res_cls_q;
  logic [tcsps_pkg::TIME_W-1:0] res_time_q;
  logic                         res_last_q;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [tcsps_pkg::TAG_W-1:0]  out_tag_q;
  logic [tcsps_pkg::TIME_W-1:0] out_time_q;
  logic                         out_status_q;
  logic                         out_last_q;

  logic                         lo_ne, hi_ne, sel;
  logic [IW-1:0]                sel_rd, cls_rd, rd_next, wr_addr;
  logic [CW-1:0]                cls_cnt;
  logic [CW:0]                  tot, wr_sum;
  logic [tcsps_pkg::TIME_W-1:0] arr_ext, time_inc;
  logic                         time_lt, loop_end, arr_full, drop_after, serve_last;
  logic                         push, drop;
  logic [SW-1:0]                lo_rdata, hi_rdata, fetched;

  assign lo_ne   = (lo_cnt_q != '0);
  assign hi_ne   = (hi_cnt_q != '0);
  // sticky choice: low if low was served last and is not empty, else high unless high is empty
  assign sel     = (served_q == tcsps_pkg::SERVED_LOW) ? !lo_ne : hi_ne;
  assign sel_rd  = sel ? hi_rd_q : lo_rd_q;
  assign rd_next = (sel_rd == RD_LAST) ? '0 : sel_rd + 1'b1;

  assign cls_rd  = cls_q ? hi_rd_q : lo_rd_q;
  assign cls_cnt = cls_q ? hi_cnt_q : lo_cnt_q;
  assign wr_sum  = (CW + 1)'(cls_rd) + (CW + 1)'(cls_cnt);
  assign wr_addr = (wr_sum >= SUM_WRAP) ? IW'(wr_sum - SUM_WRAP) : IW'(wr_sum);

  assign arr_ext  = tcsps_pkg::TIME_W'(arr_q);
  assign time_inc = time_q + 1'b1;
  assign time_lt  = (time_q < arr_ext);
  assign loop_end = (time_inc >= arr_ext);
  assign tot      = (CW + 1)'(lo_cnt_q) + (CW + 1)'(hi_cnt_q);
  assign arr_full = (cls_cnt == CNT_FULL);

  // the item will be dropped after this serve if its queue stays full
  assign drop_after = arr_full && (sel != cls_q);
  assign serve_last = cmd_i.drain ? (tot == (CW + 1)'(1))
                    : (!last_q && !drop_after && (loop_end || tot == (CW + 1)'(1)));

  assign push = cmd_i.enqueue && !arr_full;
  assign drop = cmd_i.enqueue && arr_full;

  tcsps_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_lo_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push && !cls_q),
    .wr_addr_i (wr_addr),
    .wr_data_i (tag_q),
    .rd_en_i   (cmd_i.serve && !sel),
    .rd_addr_i (sel_rd),
    .rd_data_o (lo_rdata)
  );

  tcsps_ram #(.WIDTH(SW), .DEPTH(QUEUE_DEPTH)) u_hi_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push && cls_q),
    .wr_addr_i (wr_addr),
    .wr_data_i (tag_q),
    .rd_en_i   (cmd_i.serve && sel),
    .rd_addr_i (sel_rd),
    .rd_data_o (hi_rdata)
  );

  assign fetched = res_cls_q ? hi_rdata : lo_rdata;

  always_comb begin
    lo_rd_d  = lo_rd_q;
    hi_rd_d  = hi_rd_q;
    lo_cnt_d = lo_cnt_q;
    hi_cnt_d = hi_cnt_q;
    time_d   = time_q;
    served_d = served_q;
    if (cmd_i.serve) begin
      if (sel) begin
        hi_rd_d  = rd_next;
        hi_cnt_d = hi_cnt_q - 1'b1;
      end else begin
        lo_rd_d  = rd_next;
        lo_cnt_d = lo_cnt_q - 1'b1;
      end
      served_d = {1'b0, sel};
      time_d   = time_inc;
    end
    if (cmd_i.enqueue) begin
      if (!lo_ne && !hi_ne && time_lt) begin
        time_d = arr_ext;
      end
      if (push) begin
        if (cls_q) begin
          hi_cnt_d = hi_cnt_q + 1'b1;
        end else begin
          lo_cnt_d = lo_cnt_q + 1'b1;
        end
      end
    end
    if (cmd_i.clear_state) begin
      lo_rd_d  = '0;
      hi_rd_d  = '0;
      lo_cnt_d = '0;
      hi_cnt_d = '0;
      time_d   = '0;
      served_d = tcsps_pkg::SERVED_NONE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !res_ready_i;
    if (drop || cmd_i.load_serve) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_rd_q     <= '0;
      hi_rd_q     <= '0;
      lo_cnt_q    <= '0;
      hi_cnt_q    <= '0;
      time_q      <= '0;
      served_q    <= tcsps_pkg::SERVED_NONE;
      out_valid_q <= 1'b0;
    end else begin
      lo_rd_q     <= lo_rd_d;
      hi_rd_q     <= hi_rd_d;
      lo_cnt_q    <= lo_cnt_d;
      hi_cnt_q    <= hi_cnt_d;
      time_q      <= time_d;
      served_q    <= served_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      cls_q  <= requester_class_i;
      tag_q  <= request_tag_i[SW-1:0];
      arr_q  <= arr_time_i;
      last_q <= last_arrival_i;
    end
    if (cmd_i.serve) begin
      res_cls_q  <= sel;
      res_time_q <= time_inc;
      res_last_q <= serve_last;
    end
    if (drop) begin
      out_tag_q    <= tcsps_pkg::TAG_W'(tag_q);
      out_time_q   <= '0;
      out_status_q <= tcsps_pkg::STATUS_DROPPED;
      out_last_q   <= !last_q;  // a closing item still drains its full queue
    end else if (cmd_i.load_serve) begin
      out_tag_q    <= tcsps_pkg::TAG_W'(fetched);
      out_time_q   <= res_time_q;
      out_status_q <= tcsps_pkg::STATUS_SERVED;
      out_last_q   <= res_last_q;
    end
  end

  assign sts_o.out_free  = !out_valid_q || res_ready_i;
  assign sts_o.can_serve = time_lt && (lo_ne || hi_ne);
  assign sts_o.nonempty  = lo_ne || hi_ne;
  assign sts_o.item_last = last_q;

  assign res_valid_o       = out_valid_q;
  assign done_tag_o        = out_tag_q;
  assign completion_time_o = out_time_q;
  assign result_status_o   = out_status_q;
  assign last_result_o     = out_last_q;

endmodule

// ===== src/two_class_sticky_priority_scheduler.sv =====
// Flow: an accepted item is latched, then enqueued or dropped; each request
// served on its behalf first pops its queue and reads the tag, then loads the output.
// A new item is taken only once the last is through, after any end-of-set drain
// and the state clear that follows it; a busy output register stalls each step.
// Reset: asynchronous, active low; queues empty, time zero, no class served.
// ----------------------------------------------------------------------------
// two_class_sticky_priority_scheduler: two-class sticky-priority scheduler
// Per-class FIFOs served one per time unit, keeping the class served last.
// ----------------------------------------------------------------------------
module two_class_sticky_priority_scheduler #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TAG_BITS    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcsps_req_if.sink     req_i,
  tcsps_res_if.source   res_o
);

  tcsps_pkg::cmd_t cmd;
  tcsps_pkg::sts_t sts;

  tcsps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcsps_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .requester_class_i (req_i.requester_class),
    .request_tag_i     (req_i.request_tag),
    .arr_time_i        (req_i.arr_time),
    .last_arrival_i    (req_i.last_arrival),
    .res_valid_o       (res_o.valid),
    .res_ready_i       (res_o.ready),
    .done_tag_o        (res_o.done_tag),
    .completion_time_o (res_o.completion_time),
    .result_status_o   (res_o.result_status),
    .last_result_o     (res_o.last_result)
  );

  // an item still owes results while a non-final one is pending
  a_last_before_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.last_result |-> !req_i.ready)
    else $error("non-final item pending while a new item is offered ready");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.latch_item, cmd.serve, cmd.enqueue, cmd.load_serve, cmd.clear_state}))
    else $error("conflicting datapath commands");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_serve || cmd.enqueue |-> sts.out_free)
    else $error("output register overwritten while occupied");

  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second item taken before the first was processed");

endmodule
